>>> sv/vgsf_pkg.sv
// ----------------------------------------------------------------------------
// vgsf_pkg
// shared types and constants of the voxel grid shape fill block
// ----------------------------------------------------------------------------
package vgsf_pkg;

  // grid geometry
  localparam int MAX_DIM   = 64;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int EDIM_W    = COORD_W + 1;
  localparam int ADDR_W    = 3 * COORD_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // field widths
  localparam int CMD_W      = 3;
  localparam int COORD_IN_W = 8;
  localparam int RAD_W      = 7;
  localparam int CH_W       = 8;
  localparam int COL_W      = 4 * CH_W;
  localparam int CFG_DIM_W  = 7;
  localparam int BND_W      = 10;
  localparam int SQ_W       = 2 * RAD_W;
  localparam int SUM_W      = SQ_W + 2;

  // configuration port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ       = 3'd0,
    CMD_PUT_VOXEL  = 3'd1,
    CMD_CUT_VOXEL  = 3'd2,
    CMD_PUT_BOX    = 3'd3,
    CMD_CUT_BOX    = 3'd4,
    CMD_PUT_SPHERE = 3'd5,
    CMD_CUT_SPHERE = 3'd6
  } cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DIM_X       = 3'd0,
    REG_DIM_Y       = 3'd1,
    REG_DIM_Z       = 3'd2,
    REG_PAINT_RED   = 3'd3,
    REG_PAINT_GREEN = 3'd4,
    REG_PAINT_BLUE  = 3'd5,
    REG_PAINT_ALPHA = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] dim_x;
    logic [CFG_DIM_W-1:0] dim_y;
    logic [CFG_DIM_W-1:0] dim_z;
    logic [CH_W-1:0]      paint_red;
    logic [CH_W-1:0]      paint_green;
    logic [CH_W-1:0]      paint_blue;
    logic [CH_W-1:0]      paint_alpha;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic setup;
    logic load_cnt;
    logic scan_en;
    logic rd_en;
    logic rd_cap;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic empty;
    logic is_read;
    logic is_shape;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> sv/vgsf_regs.sv
// ----------------------------------------------------------------------------
// vgsf_regs
// apb register file: grid size and paint colour
// ----------------------------------------------------------------------------
module vgsf_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vgsf_pkg::PADDR_W-1:0]  paddr,
  input  logic [vgsf_pkg::PDATA_W-1:0]  pwdata,
  output logic [vgsf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output vgsf_pkg::cfg_t                cfg
);
  import vgsf_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_x       <= DIM_RESET;
      cfg_r.dim_y       <= DIM_RESET;
      cfg_r.dim_z       <= DIM_RESET;
      cfg_r.paint_red   <= '0;
      cfg_r.paint_green <= '0;
      cfg_r.paint_blue  <= '0;
      cfg_r.paint_alpha <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_DIM_X:       cfg_r.dim_x       <= pwdata[CFG_DIM_W-1:0];
        REG_DIM_Y:       cfg_r.dim_y       <= pwdata[CFG_DIM_W-1:0];
        REG_DIM_Z:       cfg_r.dim_z       <= pwdata[CFG_DIM_W-1:0];
        REG_PAINT_RED:   cfg_r.paint_red   <= pwdata[CH_W-1:0];
        REG_PAINT_GREEN: cfg_r.paint_green <= pwdata[CH_W-1:0];
        REG_PAINT_BLUE:  cfg_r.paint_blue  <= pwdata[CH_W-1:0];
        REG_PAINT_ALPHA: cfg_r.paint_alpha <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIM_X:       prdata = PDATA_W'(cfg_r.dim_x);
      REG_DIM_Y:       prdata = PDATA_W'(cfg_r.dim_y);
      REG_DIM_Z:       prdata = PDATA_W'(cfg_r.dim_z);
      REG_PAINT_RED:   prdata = PDATA_W'(cfg_r.paint_red);
      REG_PAINT_GREEN: prdata = PDATA_W'(cfg_r.paint_green);
      REG_PAINT_BLUE:  prdata = PDATA_W'(cfg_r.paint_blue);
      REG_PAINT_ALPHA: prdata = PDATA_W'(cfg_r.paint_alpha);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> sv/vgsf_ctrl.sv
// ----------------------------------------------------------------------------
// vgsf_ctrl
// command sequencer: clear pass, bounds setup, scan, read, result hand-off
// ----------------------------------------------------------------------------
module vgsf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vgsf_pkg::dp_stat_t    stat,
  output vgsf_pkg::ctrl_cmd_t   cmd
);
  import vgsf_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SETUP  = 9'b000000100,
    S_CHECK  = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_FLUSH  = 9'b000100000,
    S_READ   = 9'b001000000,
    S_RDWAIT = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.load_cnt = 1'b1;
        if (stat.empty || !(stat.is_read || stat.is_shape)) begin
          state_nxt = S_DONE;
        end else if (stat.is_read) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        // last voxel of the scan is written from the square stage here
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is in flight");

endmodule

>>> sv/vgsf_dp.sv
// ----------------------------------------------------------------------------
// vgsf_dp
// datapath: request registers, bounds clipping, scan counters, sphere test,
// voxel memories and result register
// ----------------------------------------------------------------------------
module vgsf_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vgsf_pkg::ctrl_cmd_t                   cmd,
  output vgsf_pkg::dp_stat_t                    stat,
  input  vgsf_pkg::cfg_t                        cfg,
  input  logic [vgsf_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_x_start,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_x_end,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_y_start,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_y_end,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_z_start,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_z_end,
  input  logic [vgsf_pkg::RAD_W-1:0]            in_sphere_radius,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_voxel_on,
  output logic [vgsf_pkg::CH_W-1:0]             out_read_red,
  output logic [vgsf_pkg::CH_W-1:0]             out_read_green,
  output logic [vgsf_pkg::CH_W-1:0]             out_read_blue,
  output logic [vgsf_pkg::CH_W-1:0]             out_read_alpha
);
  import vgsf_pkg::*;

  typedef struct packed {
    logic               empty;
    logic [COORD_W-1:0] lo;
    logic [EDIM_W-1:0]  hi;
  } axis_t;

  function automatic logic signed [BND_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] d);
    if (BND_W'(d) > BND_W'(MAX_DIM)) return BND_W'(MAX_DIM);
    else return BND_W'(d);
  endfunction

  // half-open span of one axis, clipped to [0, dim)
  function automatic axis_t clip_axis(
    input logic signed [COORD_IN_W-1:0] s,
    input logic signed [COORD_IN_W-1:0] e,
    input logic [RAD_W-1:0]             r,
    input logic                         sphere,
    input logic                         box,
    input logic signed [BND_W-1:0]      edim
  );
    logic signed [BND_W-1:0] sw, ew, rw, lo, hi;
    axis_t a;
    sw = BND_W'(s);
    ew = BND_W'(e);
    rw = BND_W'(r);
    if (sphere) begin
      lo = sw - rw + BND_W'(1);
      hi = sw + rw + BND_W'(1);
    end else if (box) begin
      lo = sw;
      hi = ew;
    end else begin
      lo = sw;
      hi = sw + BND_W'(1);
    end
    if (lo < 0) lo = '0;
    if (hi > edim) hi = edim;
    a.empty = (lo >= hi);
    a.lo    = lo[COORD_W-1:0];
    a.hi    = hi[EDIM_W-1:0];
    return a;
  endfunction

  function automatic logic [RAD_W-1:0] abs_off(
    input logic signed [COORD_IN_W-1:0] c,
    input logic [COORD_W-1:0]           p
  );
    logic signed [BND_W-1:0] d;
    d = BND_W'(c) - BND_W'(p);
    if (d < 0) d = -d;
    return d[RAD_W-1:0];
  endfunction

  // request registers
  cmd_t                         cmd_r;
  logic signed [COORD_IN_W-1:0] xs_r, xe_r, ys_r, ye_r, zs_r, ze_r;
  logic [RAD_W-1:0]             rad_r;

  // clipped bounds
  logic [COORD_W-1:0] lo_x_r, lo_y_r, lo_z_r;
  logic [EDIM_W-1:0]  hi_x_r, hi_y_r, hi_z_r;
  logic               empty_r;
  logic [SQ_W-1:0]    r2_r;
  axis_t              ax, ay, az;

  logic is_put, is_sphere, is_box, is_shape;

  // scan counters
  logic [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [EDIM_W-1:0]  cx_inc, cy_inc, cz_inc;
  logic               x_wrap, y_wrap, z_wrap;

  // square stage
  logic              v1_r;
  logic [ADDR_W-1:0] addr1_r;
  logic [SQ_W-1:0]   sqx1_r, sqy1_r, sqz1_r;
  logic [RAD_W-1:0]  mx, my, mz;
  logic [SUM_W-1:0]  dist2;
  logic              hit;

  // clear pass
  logic [ADDR_W-1:0] clr_addr_r;

  // memory ports
  logic              on_mem [MEM_DEPTH];
  logic [COL_W-1:0]  col_mem [MEM_DEPTH];
  logic              on_we, col_we, on_wd;
  logic [COL_W-1:0]  col_wd;
  logic [ADDR_W-1:0] wa, ra;
  logic              rd_on_r;
  logic [COL_W-1:0]  rd_col_r;

  // result
  logic             res_on_r;
  logic [COL_W-1:0] res_col_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_on_r;
  logic [COL_W-1:0] out_col_r;

  always_comb begin
    is_put    = 1'b0;
    is_sphere = 1'b0;
    is_box    = 1'b0;
    is_shape  = 1'b0;
    case (cmd_r) inside
      CMD_PUT_VOXEL: begin
        is_put   = 1'b1;
        is_shape = 1'b1;
      end
      CMD_CUT_VOXEL: is_shape = 1'b1;
      CMD_PUT_BOX: begin
        is_put   = 1'b1;
        is_box   = 1'b1;
        is_shape = 1'b1;
      end
      CMD_CUT_BOX: begin
        is_box   = 1'b1;
        is_shape = 1'b1;
      end
      CMD_PUT_SPHERE: begin
        is_put    = 1'b1;
        is_sphere = 1'b1;
        is_shape  = 1'b1;
      end
      CMD_CUT_SPHERE: begin
        is_sphere = 1'b1;
        is_shape  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= cmd_t'(in_cmd);
      xs_r  <= in_x_start;
      xe_r  <= in_x_end;
      ys_r  <= in_y_start;
      ye_r  <= in_y_end;
      zs_r  <= in_z_start;
      ze_r  <= in_z_end;
      rad_r <= in_sphere_radius;
    end
  end

  assign ax = clip_axis(xs_r, xe_r, rad_r, is_sphere, is_box, eff_dim(cfg.dim_x));
  assign ay = clip_axis(ys_r, ye_r, rad_r, is_sphere, is_box, eff_dim(cfg.dim_y));
  assign az = clip_axis(zs_r, ze_r, rad_r, is_sphere, is_box, eff_dim(cfg.dim_z));

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      lo_x_r  <= ax.lo;
      lo_y_r  <= ay.lo;
      lo_z_r  <= az.lo;
      hi_x_r  <= ax.hi;
      hi_y_r  <= ay.hi;
      hi_z_r  <= az.hi;
      empty_r <= ax.empty | ay.empty | az.empty;
      r2_r    <= SQ_W'(rad_r) * SQ_W'(rad_r);
    end
  end

  // z runs fastest, then y, then x
  assign cx_inc = EDIM_W'(cx_r) + EDIM_W'(1);
  assign cy_inc = EDIM_W'(cy_r) + EDIM_W'(1);
  assign cz_inc = EDIM_W'(cz_r) + EDIM_W'(1);
  assign x_wrap = (cx_inc == hi_x_r);
  assign y_wrap = (cy_inc == hi_y_r);
  assign z_wrap = (cz_inc == hi_z_r);

  always_ff @(posedge clk) begin
    if (cmd.load_cnt) begin
      cx_r <= lo_x_r;
      cy_r <= lo_y_r;
      cz_r <= lo_z_r;
    end else if (cmd.scan_en) begin
      if (!z_wrap) begin
        cz_r <= cz_inc[COORD_W-1:0];
      end else begin
        cz_r <= lo_z_r;
        if (!y_wrap) begin
          cy_r <= cy_inc[COORD_W-1:0];
        end else begin
          cy_r <= lo_y_r;
          if (!x_wrap) cx_r <= cx_inc[COORD_W-1:0];
        end
      end
    end
  end

  assign mx = abs_off(xs_r, cx_r);
  assign my = abs_off(ys_r, cy_r);
  assign mz = abs_off(zs_r, cz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      addr1_r <= {cx_r, cy_r, cz_r};
      sqx1_r  <= SQ_W'(mx) * SQ_W'(mx);
      sqy1_r  <= SQ_W'(my) * SQ_W'(my);
      sqz1_r  <= SQ_W'(mz) * SQ_W'(mz);
    end
  end

  assign dist2 = SUM_W'(sqx1_r) + SUM_W'(sqy1_r) + SUM_W'(sqz1_r);
  assign hit   = !is_sphere || (dist2 < SUM_W'(r2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  always_comb begin
    if (cmd.clr_en) begin
      wa     = clr_addr_r;
      on_we  = 1'b1;
      col_we = 1'b1;
      on_wd  = 1'b0;
      col_wd = '0;
    end else begin
      wa     = addr1_r;
      on_we  = v1_r && hit;
      col_we = v1_r && hit && is_put;
      on_wd  = is_put;
      col_wd = {cfg.paint_alpha, cfg.paint_blue, cfg.paint_green, cfg.paint_red};
    end
  end

  assign ra = {cx_r, cy_r, cz_r};

  always_ff @(posedge clk) begin
    if (on_we) on_mem[wa] <= on_wd;
    if (cmd.rd_en) rd_on_r <= on_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[wa] <= col_wd;
    if (cmd.rd_en) rd_col_r <= col_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_on_r  <= 1'b0;
      res_col_r <= '0;
    end else if (cmd.rd_cap) begin
      res_on_r  <= rd_on_r;
      res_col_r <= rd_col_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_on_r  <= res_on_r;
      out_col_r <= res_col_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_voxel_on   = out_on_r;
  assign out_read_red   = out_col_r[CH_W-1:0];
  assign out_read_green = out_col_r[2*CH_W-1:CH_W];
  assign out_read_blue  = out_col_r[3*CH_W-1:2*CH_W];
  assign out_read_alpha = out_col_r[4*CH_W-1:3*CH_W];

  assign stat.clr_last  = &clr_addr_r;
  assign stat.empty     = empty_r;
  assign stat.is_read   = (cmd_r == CMD_READ);
  assign stat.is_shape  = is_shape;
  assign stat.scan_last = x_wrap & y_wrap & z_wrap;
  assign stat.out_busy  = out_valid_r & !out_ready;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && on_we))
    else $error("voxel read issued while a write is pending");

  a_no_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result register loaded over an untaken result");

  a_stage_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (addr1_r[ADDR_W-1 -: COORD_W] >= lo_x_r) &&
             (EDIM_W'(addr1_r[ADDR_W-1 -: COORD_W]) < hi_x_r))
    else $error("scan left the clipped x span");

endmodule

>>> sv/voxel_grid_shape_fill.sv
// ----------------------------------------------------------------------------
// voxel_grid_shape_fill
// 3d voxel store with read, put/cut voxel, box and sphere fill commands
// ----------------------------------------------------------------------------
//
// channel   direction  handshake               payload
// in_*      input      in_valid / in_ready     cmd, box start/end, sphere radius
// out_*     output     out_valid / out_ready   voxel_on, rgba of read voxel
// apb       input      psel+penable+pwrite     dim_x/y/z, paint rgba (4*index)
//
// - after reset a clearing pass writes every voxel off/black, one voxel a
//   cycle, with in_ready low; apb writes are taken
// - a read passes setup, check, memory read and capture; a single voxel
//   passes setup, check, scan and flush; an empty shape, an off-grid read
//   or the unused code goes from check straight to hand-off
// - a box or sphere scans its clipped span (a sphere its clipped bounding
//   cube); one voxel per cycle, set by the voxel memory's single write port
// - a waiting result sits in the output register; the next request is
//   still accepted and worked, only its own hand-off waits on out_ready
// - reset is synchronous, active low
//
module voxel_grid_shape_fill (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [vgsf_pkg::CMD_W-1:0]             in_cmd,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_x_start,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_x_end,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_y_start,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_y_end,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_z_start,
  input  logic signed [vgsf_pkg::COORD_IN_W-1:0] in_z_end,
  input  logic [vgsf_pkg::RAD_W-1:0]             in_sphere_radius,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_voxel_on,
  output logic [vgsf_pkg::CH_W-1:0]              out_read_red,
  output logic [vgsf_pkg::CH_W-1:0]              out_read_green,
  output logic [vgsf_pkg::CH_W-1:0]              out_read_blue,
  output logic [vgsf_pkg::CH_W-1:0]              out_read_alpha,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [vgsf_pkg::PADDR_W-1:0]           paddr,
  input  logic [vgsf_pkg::PDATA_W-1:0]           pwdata,
  output logic [vgsf_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);
  import vgsf_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // register file: grid size in use and paint colour for put commands
  vgsf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: clear pass, then one request at a time
  vgsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: bounds, scan, sphere test, voxel memories, output register
  vgsf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg              (cfg),
    .in_cmd           (in_cmd),
    .in_x_start       (in_x_start),
    .in_x_end         (in_x_end),
    .in_y_start       (in_y_start),
    .in_y_end         (in_y_end),
    .in_z_start       (in_z_start),
    .in_z_end         (in_z_end),
    .in_sphere_radius (in_sphere_radius),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_voxel_on     (out_voxel_on),
    .out_read_red     (out_read_red),
    .out_read_green   (out_read_green),
    .out_read_blue    (out_read_blue),
    .out_read_alpha   (out_read_alpha)
  );

endmodule
